// File: sv/two_channel_lux_calculation_top_macros.svh
// ----------------------------------------------------------------------------
// Lux calculation assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_CHANNEL_LUX_CALCULATION_TOP_MACROS_SVH
`define TWO_CHANNEL_LUX_CALCULATION_TOP_MACROS_SVH

// same-cycle implication
`define LCX_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lux calculation: same-cycle check failed");

// next-cycle implication
`define LCX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lux calculation: next-cycle check failed");

`endif

// File: sv/lcx_pkg.sv
// ----------------------------------------------------------------------------
// Lux calculation package
// Widths, coefficients, register indexes and the ratio power table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package lcx_pkg;

	localparam int CNT_W  = 16;
	localparam int LUX_W  = 32;
	localparam int NUM_W  = 54;
	localparam int DEN_W  = 30;
	localparam int DIFF_W = 28;
	localparam int K_W    = 28;
	localparam int POW_W  = 16;

	localparam logic [0:0] CFG_GAIN  = 1'b0;
	localparam logic [0:0] CFG_INTEG = 1'b1;

	localparam logic [8:0]  INTEG_RESET = 9'd402;
	localparam logic [16:0] DEN_SCALE   = 17'd100000;
	localparam logic [8:0]  NORM_MS     = 9'd402;

	localparam logic [11:0] C1_B = 12'd3040;
	localparam logic [12:0] C1_P = 13'd6200;
	localparam logic [11:0] C2_B = 12'd2240;
	localparam logic [11:0] C2_I = 12'd3100;
	localparam logic [11:0] C3_B = 12'd1280;
	localparam logic [11:0] C3_I = 12'd1530;
	localparam logic [11:0] C4_B = 12'd146;
	localparam logic [11:0] C4_I = 12'd112;

	typedef struct packed {
		logic zero;
		logic reg1;
		logic reg2;
		logic reg3;
	} lcx_flags_t;

	typedef struct packed {
		lcx_flags_t       flags;
		logic [CNT_W-1:0] bb;
		logic [CNT_W-1:0] ir;
	} lcx_pay_t;

	// largest Q16 z with z^5 * d^2 <= k^2 * 2^80
	function automatic logic [16:0] pow_root(input logic [31:0] k, input logic [31:0] d);
		logic [16:0]  lo;
		logic [16:0]  hi;
		logic [16:0]  mid;
		logic [127:0] lhs;
		logic [127:0] rhs;
		lo  = '0;
		hi  = 17'd65535;
		rhs = (128'(k) * 128'(k)) << 80;
		for (int it = 0; it < 17; it++) begin
			if (lo < hi) begin
				mid = (lo + hi + 17'd1) >> 1;
				lhs = 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid)
					* 128'(d) * 128'(d);
				if (lhs <= rhs) begin
					lo = mid;
				end else begin
					hi = mid - 17'd1;
				end
			end
		end
		return lo;
	endfunction

endpackage

`default_nettype wire

// File: sv/lcx_div.sv
// ----------------------------------------------------------------------------
// Lux calculation pipelined divider
// Restoring division, one quotient bit per register stage, with side payload.
// ----------------------------------------------------------------------------
`default_nettype none

module lcx_div #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 16,
	parameter int PAY_W = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_vld,
	input  wire logic [NUM_W-1:0] in_num,
	input  wire logic [DEN_W-1:0] in_den,
	input  wire logic [PAY_W-1:0] in_pay,
	output logic                  out_vld,
	output logic [NUM_W-1:0]      out_quo,
	output logic [PAY_W-1:0]      out_pay
);

	logic [NUM_W-1:0] vld_sn;
	logic [DEN_W-1:0] rem_sn [NUM_W];
	logic [NUM_W-1:0] nq_sn  [NUM_W];
	logic [DEN_W-1:0] den_sn [NUM_W];
	logic [PAY_W-1:0] pay_sn [NUM_W];

	for (genvar g = 0; g < NUM_W; g++) begin : g_stage
		logic             vld_i;
		logic [DEN_W-1:0] rem_i;
		logic [DEN_W-1:0] den_i;
		logic [NUM_W-1:0] nq_i;
		logic [PAY_W-1:0] pay_i;
		logic [DEN_W:0]   part;
		logic             ge;

		if (g == 0) begin : g_first
			assign vld_i = in_vld;
			assign rem_i = '0;
			assign den_i = in_den;
			assign nq_i  = in_num;
			assign pay_i = in_pay;
		end else begin : g_next
			assign vld_i = vld_sn[g-1];
			assign rem_i = rem_sn[g-1];
			assign den_i = den_sn[g-1];
			assign nq_i  = nq_sn[g-1];
			assign pay_i = pay_sn[g-1];
		end

		assign part = {rem_i, nq_i[NUM_W-1]};
		assign ge   = part >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[g] <= 1'b0;
			end else if (adv) begin
				vld_sn[g] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sn[g] <= ge ? DEN_W'(part - {1'b0, den_i}) : part[DEN_W-1:0];
				nq_sn[g]  <= {nq_i[NUM_W-2:0], ge};
				den_sn[g] <= den_i;
				pay_sn[g] <= pay_i;
			end
		end
	end

	assign out_vld = vld_sn[NUM_W-1];
	assign out_quo = nq_sn[NUM_W-1];
	assign out_pay = pay_sn[NUM_W-1];

endmodule

`default_nettype wire

// File: sv/two_channel_lux_calculation_top.sv
// ----------------------------------------------------------------------------
// Two-channel lux calculation
// Accepts one item per cycle and returns one result per item in order. Two
// bit-per-stage divider pipelines (count ratio, then final scaling) make up most
// of the pipeline, with the table lookup and multiply stages between them. A
// stalled output holds the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_channel_lux_calculation_top_macros.svh"

module two_channel_lux_calculation_top #(
	parameter int POWER_TABLE_ENTRIES = 256,
	parameter int RATIO_FRACTION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // broadband_count[15:0], infrared_count[31:16]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // lux_value[31:0]
	output logic [0:0]       m_tuser,   // saturated[0]
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);

	localparam int TBL_DIV = 2 * (POWER_TABLE_ENTRIES - 1);
	localparam int IDX_W   = $clog2(POWER_TABLE_ENTRIES);
	localparam int RNUM_W  = lcx_pkg::CNT_W + RATIO_FRACTION_BITS;
	localparam int RAT_W   = RATIO_FRACTION_BITS + 1;
	localparam int DV_W    = $clog2(TBL_DIV + 1);
	localparam int PROD_W  = RAT_W + DV_W + 1;
	localparam int PAY_W   = $bits(lcx_pkg::lcx_pay_t);

	localparam int NW = lcx_pkg::NUM_W;
	localparam int DW = lcx_pkg::DEN_W;

	logic adv;
	logic gain_q;
	logic [8:0] integ_q;
	logic [DW-1:0] den_q;

	logic [15:0] pow_tbl [POWER_TABLE_ENTRIES];

	for (genvar k = 0; k < POWER_TABLE_ENTRIES; k++) begin : g_tbl
		localparam logic [16:0] ZR = lcx_pkg::pow_root(32'(k), 32'(TBL_DIV));
		localparam int unsigned PV = (k * int'(ZR)) / TBL_DIV;
		assign pow_tbl[k] = 16'(PV);
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= 1'b0;
			integ_q <= lcx_pkg::INTEG_RESET;
		end else if (cfg_we && cfg_index[1] == 1'b0) begin
			case (cfg_index[0])
				lcx_pkg::CFG_GAIN:  gain_q  <= cfg_data[0];
				lcx_pkg::CFG_INTEG: integ_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [8:0]  integ_eff;
	logic [25:0] den_base;
	assign integ_eff = (integ_q == 9'd0) ? 9'd1 : integ_q;
	assign den_base  = 26'(lcx_pkg::DEN_SCALE) * 26'(integ_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= DW'(26'(lcx_pkg::DEN_SCALE) * 26'(lcx_pkg::INTEG_RESET));
		end else begin
			den_q <= gain_q ? {den_base, 4'b0} : DW'(den_base);
		end
	end

	// stage 1: register counts, decide region
	logic [15:0] bb_in;
	logic [15:0] ir_in;
	lcx_pkg::lcx_flags_t flags_in;
	assign bb_in = s_tdata[15:0];
	assign ir_in = s_tdata[31:16];

	always_comb begin
		flags_in.zero = (bb_in == 16'd0) || (20'(ir_in) * 20'd10 > 20'(bb_in) * 20'd13);
		flags_in.reg1 = {ir_in, 1'b0} <= 17'(bb_in);
		flags_in.reg2 = 23'(ir_in) * 23'd100 <= 23'(bb_in) * 23'd61;
		flags_in.reg3 = 19'(ir_in) * 19'd5 <= 19'(bb_in) * 19'd4;
	end

	logic v_s1;
	lcx_pkg::lcx_pay_t pay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s1.flags <= flags_in;
			pay_s1.bb    <= bb_in;
			pay_s1.ir    <= ir_in;
		end
	end

	// ratio divider
	logic d1_vld;
	logic [RNUM_W-1:0] d1_quo;
	logic [PAY_W-1:0] d1_pay_raw;
	lcx_pkg::lcx_pay_t d1_pay;

	lcx_div #(
		.NUM_W(RNUM_W),
		.DEN_W(lcx_pkg::CNT_W),
		.PAY_W(PAY_W)
	) u_ratio_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_vld (v_s1),
		.in_num ({pay_s1.ir, RATIO_FRACTION_BITS'(0)}),
		.in_den (pay_s1.bb),
		.in_pay (PAY_W'(pay_s1)),
		.out_vld(d1_vld),
		.out_quo(d1_quo),
		.out_pay(d1_pay_raw)
	);

	assign d1_pay = lcx_pkg::lcx_pay_t'(d1_pay_raw);

	// stage 2: table index and linear region difference
	logic [PROD_W-1:0] prod;
	logic [PROD_W-RATIO_FRACTION_BITS-1:0] idx_full;
	logic [IDX_W-1:0] idx_c;
	logic [lcx_pkg::DIFF_W-1:0] ca;
	logic [lcx_pkg::DIFF_W-1:0] cc;
	logic [lcx_pkg::DIFF_W-1:0] diff_c;

	always_comb begin
		prod = PROD_W'(d1_quo[RAT_W-1:0]) * PROD_W'(TBL_DIV)
			+ (PROD_W'(1) << (RATIO_FRACTION_BITS - 1));
		idx_full = prod[PROD_W-1:RATIO_FRACTION_BITS];
		if (idx_full > (PROD_W-RATIO_FRACTION_BITS)'(POWER_TABLE_ENTRIES - 1)) begin
			idx_c = IDX_W'(POWER_TABLE_ENTRIES - 1);
		end else begin
			idx_c = idx_full[IDX_W-1:0];
		end
		if (d1_pay.flags.reg2) begin
			ca = lcx_pkg::DIFF_W'(d1_pay.bb) * lcx_pkg::DIFF_W'(lcx_pkg::C2_B);
			cc = lcx_pkg::DIFF_W'(d1_pay.ir) * lcx_pkg::DIFF_W'(lcx_pkg::C2_I);
		end else if (d1_pay.flags.reg3) begin
			ca = lcx_pkg::DIFF_W'(d1_pay.bb) * lcx_pkg::DIFF_W'(lcx_pkg::C3_B);
			cc = lcx_pkg::DIFF_W'(d1_pay.ir) * lcx_pkg::DIFF_W'(lcx_pkg::C3_I);
		end else begin
			ca = lcx_pkg::DIFF_W'(d1_pay.bb) * lcx_pkg::DIFF_W'(lcx_pkg::C4_B);
			cc = lcx_pkg::DIFF_W'(d1_pay.ir) * lcx_pkg::DIFF_W'(lcx_pkg::C4_I);
		end
		diff_c = (ca >= cc) ? ca - cc : '0;
	end

	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [IDX_W-1:0] idx_s2;
	logic [lcx_pkg::DIFF_W-1:0] diff_s2, diff_s3, diff_s4, diff_s5;
	logic [15:0] bb_s2, bb_s3, bb_s4;
	logic reg1_s2, reg1_s3, reg1_s4, reg1_s5;
	logic zero_s2, zero_s3, zero_s4, zero_s5, zero_s6, zero_s7;
	logic [lcx_pkg::POW_W-1:0] pow_s3;
	logic [lcx_pkg::K_W-1:0] k_s4;
	logic [43:0] bbk_s5;
	logic [NW-1:0] num_s6, num_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s2 <= d1_vld;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s2  <= idx_c;
			diff_s2 <= diff_c;
			bb_s2   <= d1_pay.bb;
			reg1_s2 <= d1_pay.flags.reg1;
			zero_s2 <= d1_pay.flags.zero;

			pow_s3  <= pow_tbl[idx_s2];
			diff_s3 <= diff_s2;
			bb_s3   <= bb_s2;
			reg1_s3 <= reg1_s2;
			zero_s3 <= zero_s2;

			k_s4    <= (lcx_pkg::K_W'(lcx_pkg::C1_B) << 16)
				- lcx_pkg::K_W'(pow_s3) * lcx_pkg::K_W'(lcx_pkg::C1_P);
			diff_s4 <= diff_s3;
			bb_s4   <= bb_s3;
			reg1_s4 <= reg1_s3;
			zero_s4 <= zero_s3;

			bbk_s5  <= 44'(bb_s4) * 44'(k_s4);
			diff_s5 <= diff_s4;
			reg1_s5 <= reg1_s4;
			zero_s5 <= zero_s4;

			num_s6  <= reg1_s5 ? NW'(bbk_s5) * NW'(lcx_pkg::NORM_MS)
				: {NW'(diff_s5) * NW'(lcx_pkg::NORM_MS)} << 16;
			zero_s6 <= zero_s5;

			num_s7  <= num_s6 + NW'(den_q >> 1);
			zero_s7 <= zero_s6;
		end
	end

	// final scaling divider
	logic d2_vld;
	logic [NW-1:0] d2_quo;
	logic [0:0] d2_zero;

	lcx_div #(
		.NUM_W(NW),
		.DEN_W(DW),
		.PAY_W(1)
	) u_scale_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_vld (v_s7),
		.in_num (num_s7),
		.in_den (den_q),
		.in_pay (zero_s7),
		.out_vld(d2_vld),
		.out_quo(d2_quo),
		.out_pay(d2_zero)
	);

	// output register
	logic out_vld_q;
	logic [31:0] lux_q;
	logic sat_q;
	logic over;
	assign over = |d2_quo[NW-1:lcx_pkg::LUX_W];

	assign adv = !out_vld_q || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (d2_zero[0]) begin
				lux_q <= '0;
				sat_q <= 1'b0;
			end else begin
				lux_q <= over ? '1 : d2_quo[lcx_pkg::LUX_W-1:0];
				sat_q <= over;
			end
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = lux_q;
	assign m_tuser[0] = sat_q;

	`LCX_ASSERT_NOW(a_sat_full, m_tvalid && m_tuser[0], m_tdata == 32'hFFFF_FFFF)
	`LCX_ASSERT_NOW(a_den_nonzero, 1'b1, den_q != '0)
	`LCX_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

`default_nettype wire
